[hw/rtl/lru_pkg.sv]
// ----------------------------------------------------------------------------
// lru_pkg
// Shared types and codes for the true-LRU replacement block.
// ----------------------------------------------------------------------------
package lru_pkg;

  // fixed payload widths of the channels
  localparam int unsigned BLOCK_IDX_W = 3;
  localparam int unsigned MODE_W      = 2;

  // access modes
  typedef enum logic [MODE_W-1:0] {
    MODE_TOUCH      = 2'd0,
    MODE_REPLACE    = 2'd1,
    MODE_INVALIDATE = 2'd2,
    MODE_NONE       = 2'd3
  } mode_t;

  // command from the item register to the rank table
  typedef struct packed {
    logic                   touch_en;
    logic                   replace_en;
    logic                   clear_en;
    logic [BLOCK_IDX_W-1:0] block_index;
  } lru_cmd_t;

  // replacement answer from the rank table
  typedef struct packed {
    logic [BLOCK_IDX_W-1:0] victim_index;
    logic                   victim_was_free;
  } lru_res_t;

endpackage

[hw/rtl/lru_if.sv]
// ----------------------------------------------------------------------------
// lru_if
// Valid/ready channels for access items and replacement results.
// ----------------------------------------------------------------------------
interface lru_in_if;
  import lru_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [MODE_W-1:0]      mode;
  logic [BLOCK_IDX_W-1:0] block_index;

  modport source (output valid, output mode, output block_index, input ready);
  modport sink   (input valid, input mode, input block_index, output ready);
endinterface

interface lru_out_if;
  import lru_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [BLOCK_IDX_W-1:0] victim_index;
  logic                   victim_was_free;

  modport source (output valid, output victim_index, output victim_was_free, input ready);
  modport sink   (input valid, input victim_index, input victim_was_free, output ready);
endinterface

[hw/rtl/lru_replacement_policy.sv]
// ----------------------------------------------------------------------------
// lru_replacement_policy
// True least-recently-used order over NUM_BLOCKS cache blocks.
//
//   channel  dir  carries                           handshake
//   in_ch    in   mode, block_index                 valid/ready
//   out_ch   out  victim_index, victim_was_free     valid/ready
//
// One item per cycle while no replacement item waits. An item sits in the item
// register while the rank table updates and a replacement result is written to
// the result register; the result passes through the item register and then the
// result register before it can be taken. Reset (synchronous, active low) empties
// the order. A replacement item waits in the item register while the result
// register holds an untaken result; touch and invalidate items never wait.
// ----------------------------------------------------------------------------
module lru_replacement_policy
  import lru_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  lru_in_if.sink     in_ch,
  lru_out_if.source  out_ch
);

  logic                   in_valid_r;
  logic [MODE_W-1:0]      in_mode_r;
  logic [BLOCK_IDX_W-1:0] in_idx_r;
  logic                   out_valid_r;
  lru_res_t               out_res_r;

  logic     is_replace;
  logic     go;
  lru_cmd_t cmd;
  lru_res_t res;

  // held item may proceed unless it needs a result slot that is still full and not being taken
  assign is_replace = (in_mode_r == MODE_REPLACE);
  assign go         = in_valid_r && (!is_replace || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || go;

  assign cmd.touch_en    = go && (in_mode_r == MODE_TOUCH);
  assign cmd.replace_en  = go && is_replace;
  assign cmd.clear_en    = go && (in_mode_r == MODE_INVALIDATE);
  assign cmd.block_index = in_idx_r;

  lru_rank_table #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_rank_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .res   (res)
  );

  // item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_mode_r <= in_ch.mode;
      in_idx_r  <= in_ch.block_index;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.replace_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.replace_en) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.victim_index    = out_res_r.victim_index;
  assign out_ch.victim_was_free = out_res_r.victim_was_free;

endmodule

[hw/rtl/lru_rank_table.sv]
// ----------------------------------------------------------------------------
// lru_rank_table
// Recency ranks, membership bits and fill count, with a registered update
// built from parallel rank compares.
// ----------------------------------------------------------------------------
module lru_rank_table
  import lru_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  lru_cmd_t cmd,
  output lru_res_t res
);

  localparam int unsigned IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned EXT_W  = IDX_W + BLOCK_IDX_W;

  logic [RANK_W-1:0] rank_r     [NUM_BLOCKS];
  logic [RANK_W-1:0] rank_nxt   [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] in_order_r, in_order_nxt;
  logic [CNT_W-1:0]  used_count_r, used_count_nxt;

  logic              full;
  logic [IDX_W-1:0]  pick_free, pick_lru, pick;
  logic [EXT_W-1:0]  idx_ext, pick_ext;
  logic              idx_in_range;
  logic              upd_en;
  logic [IDX_W-1:0]  target;
  logic [RANK_W-1:0] target_rank;

  // touch index widened so the range check holds for any block count
  assign idx_ext      = {{IDX_W{1'b0}}, cmd.block_index};
  assign idx_in_range = (idx_ext < EXT_W'(NUM_BLOCKS));

  assign full = (used_count_r == CNT_W'(NUM_BLOCKS));

  // lowest-numbered block outside the order
  always_comb begin
    pick_free = '0;
    for (int j = NUM_BLOCKS - 1; j >= 0; j--) begin
      if (!in_order_r[j]) pick_free = IDX_W'(j);
    end
  end

  // least recent block, only meaningful when the order is full
  always_comb begin
    pick_lru = '0;
    for (int j = 0; j < NUM_BLOCKS; j++) begin
      if (in_order_r[j] && (rank_r[j] == '0)) pick_lru = IDX_W'(j);
    end
  end

  assign pick = full ? pick_lru : pick_free;

  // result: low bits of the chosen block number
  assign pick_ext            = {{BLOCK_IDX_W{1'b0}}, pick};
  assign res.victim_index    = pick_ext[BLOCK_IDX_W-1:0];
  assign res.victim_was_free = !full;

  // block to promote to most recent
  assign upd_en      = cmd.replace_en || (cmd.touch_en && idx_in_range);
  assign target      = cmd.replace_en ? pick : idx_ext[IDX_W-1:0];
  assign target_rank = rank_r[target];

  // next order: clear, or close gap above old rank and put target on top
  always_comb begin
    for (int j = 0; j < NUM_BLOCKS; j++) rank_nxt[j] = rank_r[j];
    in_order_nxt   = in_order_r;
    used_count_nxt = used_count_r;
    if (cmd.clear_en) begin
      for (int j = 0; j < NUM_BLOCKS; j++) rank_nxt[j] = '0;
      in_order_nxt   = '0;
      used_count_nxt = '0;
    end else if (upd_en) begin
      if (in_order_r[target]) begin
        for (int j = 0; j < NUM_BLOCKS; j++) begin
          if (in_order_r[j] && (rank_r[j] > target_rank)) rank_nxt[j] = rank_r[j] - 1'b1;
        end
        rank_nxt[target] = RANK_W'(used_count_r - 1'b1);
      end else begin
        rank_nxt[target]     = RANK_W'(used_count_r);
        in_order_nxt[target] = 1'b1;
        used_count_nxt       = used_count_r + 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_BLOCKS; j++) rank_r[j] <= '0;
      in_order_r   <= '0;
      used_count_r <= '0;
    end else begin
      for (int j = 0; j < NUM_BLOCKS; j++) rank_r[j] <= rank_nxt[j];
      in_order_r   <= in_order_nxt;
      used_count_r <= used_count_nxt;
    end
  end

endmodule
